/* sv/adq_pkg.sv */
// ----------------------------------------------------------------------------
// adq_pkg
// Shared constants, codes and control types for the array deque block.
// ----------------------------------------------------------------------------
package adq_pkg;

  // default geometry
  localparam int DEPTH_DEF = 1024;
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STS_W     = 2;
  localparam int CNT_W_DEF = $clog2(DEPTH_DEF + 1);

  // command codes, unused codes behave as status only
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd4;

  // result status codes
  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STS_W-1:0] ST_UNDERFLOW = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic take;   // input word accepted this cycle
    logic fill;   // store read data is valid, finish the pop
    logic load;   // capture the result register
  } adq_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic needs_read;   // presented command is a pop that exposes a stored word
  } adq_sts_t;

endpackage

/* sv/adq_in_if.sv */
// ----------------------------------------------------------------------------
// adq_in_if
// Command channel: valid/ready handshake carrying command and push word.
// ----------------------------------------------------------------------------
interface adq_in_if;
  import adq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);

endinterface

/* sv/adq_out_if.sv */
// ----------------------------------------------------------------------------
// adq_out_if
// Result channel: valid/ready handshake carrying status and deque snapshot.
// ----------------------------------------------------------------------------
interface adq_out_if #(
  parameter int CNT_W = adq_pkg::CNT_W_DEF
);
  import adq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STS_W-1:0]         status;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] back_value;
  logic [CNT_W-1:0]         count;
  logic                     is_empty;

  modport source (output valid, output status, output front_value, output back_value,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input status, input front_value, input back_value,
                  input count, input is_empty, output ready);

endinterface

/* sv/adq_ctrl.sv */
// ----------------------------------------------------------------------------
// adq_ctrl
// Controller: sequences accept, store read wait and result hand-off.
// ----------------------------------------------------------------------------
module adq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  adq_pkg::adq_sts_t sts,
  output adq_pkg::adq_ctl_t ctl
);
  import adq_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE,
    S_FETCH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // take a word only when the result register is free by the next edge
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  // datapath commands
  always_comb begin
    ctl.take = in_valid && in_ready;
    ctl.fill = (state_r == S_FETCH);
    ctl.load = (ctl.take && !sts.needs_read) || ctl.fill;
  end

  // next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.load) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        if (ctl.take && sts.needs_read) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/adq_dpath.sv */
// ----------------------------------------------------------------------------
// adq_dpath
// Datapath: word store, front and rear indices, end words and result register.
// ----------------------------------------------------------------------------
module adq_dpath #(
  parameter int DEPTH = adq_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  adq_pkg::adq_ctl_t                ctl,
  output adq_pkg::adq_sts_t                sts,
  input  logic [adq_pkg::CMD_W-1:0]        in_command,
  input  logic signed [adq_pkg::WORD_W-1:0] in_value,
  output logic [adq_pkg::STS_W-1:0]        out_status,
  output logic signed [adq_pkg::WORD_W-1:0] out_front_value,
  output logic signed [adq_pkg::WORD_W-1:0] out_back_value,
  output logic [CNT_W-1:0]                 out_count,
  output logic                             out_is_empty
);
  import adq_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // word store
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;

  // deque state
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic              empty_r, empty_nxt;
  logic              front_pop_r, front_pop_nxt;
  logic [WORD_W-1:0] front_r, front_nxt;
  logic [WORD_W-1:0] back_r, back_nxt;
  logic [STS_W-1:0]  status_nxt;

  // outcome of the presented command
  logic [IDX_W-1:0]  t_head, t_tail;
  logic              t_empty, t_wr, t_read, t_front_pop;
  logic [WORD_W-1:0] t_front, t_back;
  logic [STS_W-1:0]  t_status;

  // result register
  logic [STS_W-1:0]  res_status_r;
  logic [WORD_W-1:0] res_front_r, res_back_r;
  logic [CNT_W-1:0]  res_count_r;
  logic              res_empty_r;

  // command decode
  always_comb begin
    t_head      = head_r;
    t_tail      = tail_r;
    t_empty     = empty_r;
    t_front     = front_r;
    t_back      = back_r;
    t_status    = ST_OK;
    t_wr        = 1'b0;
    t_read      = 1'b0;
    t_front_pop = front_pop_r;
    wr_addr     = head_r;
    rd_addr     = head_r + IDX_W'(1);
    case (in_command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (empty_r) begin
          t_head  = '0;
          t_tail  = '0;
          t_empty = 1'b0;
          t_front = in_value;
          t_back  = in_value;
          t_wr    = 1'b1;
          wr_addr = '0;
        end else if (in_command == CMD_PUSH_FRONT) begin
          if (head_r == '0) begin
            t_status = ST_OVERFLOW;
          end else begin
            t_head  = head_r - IDX_W'(1);
            t_front = in_value;
            t_wr    = 1'b1;
            wr_addr = head_r - IDX_W'(1);
          end
        end else begin
          if (tail_r == LAST_IDX) begin
            t_status = ST_OVERFLOW;
          end else begin
            t_tail  = tail_r + IDX_W'(1);
            t_back  = in_value;
            t_wr    = 1'b1;
            wr_addr = tail_r + IDX_W'(1);
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty_r) begin
          t_status = ST_UNDERFLOW;
        end else if (head_r == tail_r) begin
          t_head  = '0;
          t_tail  = '0;
          t_empty = 1'b1;
        end else if (in_command == CMD_POP_FRONT) begin
          t_head      = head_r + IDX_W'(1);
          t_read      = 1'b1;
          t_front_pop = 1'b1;
          rd_addr     = head_r + IDX_W'(1);
        end else begin
          t_tail      = tail_r - IDX_W'(1);
          t_read      = 1'b1;
          t_front_pop = 1'b0;
          rd_addr     = tail_r - IDX_W'(1);
        end
      end
      default: begin
        t_status = ST_OK;
      end
    endcase
  end

  assign sts.needs_read = t_read;
  assign wr_en          = ctl.take && t_wr;

  // next state: take a command, finish a pop or hold
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    front_pop_nxt = front_pop_r;
    status_nxt    = ST_OK;
    if (ctl.take) begin
      head_nxt      = t_head;
      tail_nxt      = t_tail;
      empty_nxt     = t_empty;
      front_nxt     = t_front;
      back_nxt      = t_back;
      front_pop_nxt = t_front_pop;
      status_nxt    = t_status;
    end else if (ctl.fill) begin
      if (front_pop_r) begin
        front_nxt = rd_data_r;
      end else begin
        back_nxt = rd_data_r;
      end
    end
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      front_pop_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      front_pop_r <= front_pop_nxt;
    end
  end

  // end words and result register
  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    back_r  <= back_nxt;
    if (ctl.load) begin
      res_status_r <= status_nxt;
      res_empty_r  <= empty_nxt;
      res_front_r  <= empty_nxt ? '1 : front_nxt;
      res_back_r   <= empty_nxt ? '1 : back_nxt;
      res_count_r  <= empty_nxt ? '0
                    : CNT_W'(tail_nxt) - CNT_W'(head_nxt) + CNT_W'(1);
    end
  end

  assign out_status      = res_status_r;
  assign out_front_value = res_front_r;
  assign out_back_value  = res_back_r;
  assign out_count       = res_count_r;
  assign out_is_empty    = res_empty_r;

endmodule

/* sv/array_deque.sv */
// Results: push, status, underflow and pop of the last word load the result
// register as the command word is taken; other pops first wait for the store read.
// Throughput: one command per cycle while results are taken, but a pop that
// exposes a stored word blocks input on the registered read port of the word store.
// Reset: indices zero and deque empty; store contents are not cleared.
// ----------------------------------------------------------------------------
// array_deque
// Double-ended queue of signed words in a linear array, one result per command.
// ----------------------------------------------------------------------------
module array_deque #(
  parameter int DEPTH = adq_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  adq_in_if.sink    in_ch,
  adq_out_if.source out_ch
);
  import adq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  adq_ctl_t ctl;
  adq_sts_t sts;

  // sequencing
  adq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // store, indices and result register
  adq_dpath #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_command      (in_ch.command),
    .in_value        (in_ch.value),
    .out_status      (out_ch.status),
    .out_front_value (out_ch.front_value),
    .out_back_value  (out_ch.back_value),
    .out_count       (out_ch.count),
    .out_is_empty    (out_ch.is_empty)
  );

`ifndef NO_ASSERTIONS
  // a finished pop never overwrites a result still waiting
  a_fill_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fill |-> !out_ch.valid)
    else $error("pop completion while result word still pending");

  // a pop that needs the store completes in the following cycle
  a_fill_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.take && sts.needs_read) |=> ctl.fill)
    else $error("store read not completed after pop");

  // an empty snapshot reports no words and all-ones ends
  a_empty_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_empty) |->
      (out_ch.count == '0 && out_ch.front_value == -32'sd1 &&
       out_ch.back_value == -32'sd1))
    else $error("empty result carries data");

  // a non-empty snapshot counts at least one word
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.is_empty) |-> (out_ch.count != '0))
    else $error("non-empty result with zero count");
`endif

endmodule
